### rtl/stri_pkg.sv
// ----------------------------------------------------------------------------
// stri_pkg
// Shared constants, register codes and symbol lookup for the radix text block.
// ----------------------------------------------------------------------------
`default_nettype none

package stri_pkg;

  localparam int unsigned NumberWidthDefault = 32;
  localparam int unsigned HeldSymbols        = 16;
  localparam int unsigned MaxSymbols         = 16;
  localparam int unsigned DigitW             = 4;
  localparam int unsigned SymW               = 8;
  localparam int unsigned CountW             = 5;
  localparam int unsigned AlphaW             = 64;
  localparam int unsigned CfgIdxW            = 2;
  localparam int unsigned DivStep            = 8;

  localparam logic [SymW-1:0]   ChPlus     = 8'h2B;
  localparam logic [SymW-1:0]   ChMinus    = 8'h2D;
  localparam logic [CountW-1:0] CountRst   = 5'd10;
  localparam logic [AlphaW-1:0] AlphaLoRst = 64'h3736_3534_3332_3130;
  localparam logic [AlphaW-1:0] AlphaHiRst = 64'h0000_0000_0000_3938;

  typedef enum logic [CfgIdxW-1:0] {
    RegCount   = 2'd0,
    RegAlphaLo = 2'd1,
    RegAlphaHi = 2'd2
  } cfg_reg_e;

  function automatic logic [SymW-1:0] sym_at(input logic [HeldSymbols*SymW-1:0] alpha,
                                             input logic [DigitW-1:0] d);
    return alpha[{d, 3'b000} +: SymW];
  endfunction

endpackage

`default_nettype wire

### rtl/stri_front.sv
// ----------------------------------------------------------------------------
// stri_front
// Accepts a number, checks the alphabet, and peels off digits least
// significant first with a shared divide unit of DivStep bits per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module stri_front #(
  parameter int unsigned NUMBER_WIDTH = stri_pkg::NumberWidthDefault,
  localparam int unsigned NdW = $clog2(NUMBER_WIDTH + 1)
) (
  input  logic                                              clk_i,
  input  logic                                              rst_ni,
  input  logic                                              start_i,
  output logic                                              busy_o,
  input  logic signed [NUMBER_WIDTH-1:0]                    number_i,
  input  logic [stri_pkg::CountW-1:0]                       count_i,
  input  logic [stri_pkg::HeldSymbols*stri_pkg::SymW-1:0]   alpha_i,
  input  logic                                              full_i,
  output logic                                              push_o,
  output logic                                              neg_o,
  output logic [NdW-1:0]                                    nd_o,
  output logic [NUMBER_WIDTH*stri_pkg::DigitW-1:0]          digits_o
);
  import stri_pkg::*;

  localparam int unsigned DivCycles = (NUMBER_WIDTH + DivStep - 1) / DivStep;
  localparam int unsigned PadW      = DivCycles * DivStep;
  localparam int unsigned CycW      = (DivCycles > 1) ? $clog2(DivCycles) : 1;
  localparam int unsigned IdxW      = $clog2(NUMBER_WIDTH);

  typedef enum logic [3:0] {
    FIdle  = 4'b0001,
    FCheck = 4'b0010,
    FDiv   = 4'b0100,
    FPush  = 4'b1000
  } front_state_e;

  front_state_e              state_q, state_d;
  logic                      ok_q, ok_d;
  logic [CycW-1:0]           cyc_q;
  logic [NdW-1:0]            nd_q;
  logic [NUMBER_WIDTH-1:0]   num_q;
  logic                      neg_q;
  logic [PadW-1:0]           div_q;
  logic [DigitW-1:0]         rem_q;
  logic [DigitW-1:0]         dig_q [NUMBER_WIDTH];

  logic [NUMBER_WIDTH-1:0]   mag;
  logic [PadW-1:0]           quo;
  logic [DigitW-1:0]         rem_n;
  logic [DigitW:0]           trial;
  logic                      last_cyc;
  logic [NdW-1:0]            nd_inc;
  logic                      stop;

  // alphabet check
  always_comb begin
    ok_d = (count_i >= CountW'(2)) && (count_i <= CountW'(MaxSymbols))
           && (count_i <= CountW'(HeldSymbols));
    for (int i = 0; i < HeldSymbols; i++) begin
      if (CountW'(i) < count_i) begin
        if (sym_at(alpha_i, DigitW'(i)) == '0 || sym_at(alpha_i, DigitW'(i)) == ChPlus
            || sym_at(alpha_i, DigitW'(i)) == ChMinus) begin
          ok_d = 1'b0;
        end
        for (int j = i + 1; j < HeldSymbols; j++) begin
          if (CountW'(j) < count_i
              && sym_at(alpha_i, DigitW'(j)) == sym_at(alpha_i, DigitW'(i))) begin
            ok_d = 1'b0;
          end
        end
      end
    end
  end

  assign mag = num_q[NUMBER_WIDTH-1] ? (~num_q + 1'b1) : num_q;

  // restoring division, DivStep quotient bits per cycle
  always_comb begin
    quo   = div_q;
    rem_n = rem_q;
    trial = '0;
    for (int k = 0; k < DivStep; k++) begin
      trial = {rem_n, quo[PadW-1]};
      quo   = {quo[PadW-2:0], 1'b0};
      if (trial >= count_i) begin
        trial  = trial - count_i;
        quo[0] = 1'b1;
      end
      rem_n = trial[DigitW-1:0];
    end
  end

  assign last_cyc = (cyc_q == CycW'(DivCycles - 1));
  assign nd_inc   = nd_q + 1'b1;
  assign stop     = (quo == '0) || (nd_inc == NdW'(NUMBER_WIDTH));

  always_comb begin
    state_d = state_q;
    case (state_q)
      FIdle: begin
        if (start_i) state_d = FCheck;
      end
      FCheck: begin
        state_d = ok_q ? FDiv : FIdle;
      end
      FDiv: begin
        if (last_cyc && stop) state_d = FPush;
      end
      FPush: begin
        if (!full_i) state_d = FIdle;
      end
      default: state_d = FIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FIdle;
      ok_q    <= 1'b0;
      cyc_q   <= '0;
      nd_q    <= '0;
    end else begin
      state_q <= state_d;
      ok_q    <= ok_d;
      if (state_q == FCheck) begin
        cyc_q <= '0;
        nd_q  <= '0;
      end else if (state_q == FDiv) begin
        if (last_cyc) begin
          cyc_q <= '0;
          nd_q  <= nd_inc;
        end else begin
          cyc_q <= cyc_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == FIdle && start_i) begin
      num_q <= number_i;
    end
    if (state_q == FCheck) begin
      neg_q <= num_q[NUMBER_WIDTH-1];
      div_q <= PadW'(mag);
      rem_q <= '0;
    end
    if (state_q == FDiv) begin
      div_q <= quo;
      if (last_cyc) begin
        rem_q                     <= '0;
        dig_q[nd_q[IdxW-1:0]]     <= rem_n;
      end else begin
        rem_q <= rem_n;
      end
    end
  end

  for (genvar g = 0; g < NUMBER_WIDTH; g++) begin : g_flat
    assign digits_o[g*DigitW +: DigitW] = dig_q[g];
  end

  assign busy_o = (state_q != FIdle);
  assign push_o = (state_q == FPush) && !full_i;
  assign neg_o  = neg_q;
  assign nd_o   = nd_q;

  a_bad_alpha_drops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == FCheck && !ok_q) |=> (state_q == FIdle))
    else $error("number with bad alphabet not dropped");

  a_nd_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == FPush) |-> (nd_q != '0 && nd_q <= NdW'(NUMBER_WIDTH)))
    else $error("digit count out of range at push");

endmodule

`default_nettype wire

### rtl/stri_queue.sv
// ----------------------------------------------------------------------------
// stri_queue
// Two-entry queue of digit strings between the divide front and the emitter.
// ----------------------------------------------------------------------------
`default_nettype none

module stri_queue #(
  parameter int unsigned WIDTH = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);
  localparam int unsigned Depth = 2;

  logic [WIDTH-1:0] mem_q [Depth];
  logic             wr_q;
  logic             rd_q;
  logic [1:0]       cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i)  rd_q <= ~rd_q;
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

  assign data_o  = mem_q[rd_q];
  assign full_o  = (cnt_q == 2'(Depth));
  assign empty_o = (cnt_q == '0);

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("queue pop while empty");

endmodule

`default_nettype wire

### rtl/stri_back.sv
// ----------------------------------------------------------------------------
// stri_back
// Emits the sign if negative, then the queue head's digits, most significant
// first, one character per cycle within a string, via a registered output.
// ----------------------------------------------------------------------------
`default_nettype none

module stri_back #(
  parameter int unsigned NUMBER_WIDTH = stri_pkg::NumberWidthDefault,
  localparam int unsigned NdW = $clog2(NUMBER_WIDTH + 1)
) (
  input  logic                                              clk_i,
  input  logic                                              rst_ni,
  input  logic                                              empty_i,
  input  logic                                              neg_i,
  input  logic [NdW-1:0]                                    nd_i,
  input  logic [NUMBER_WIDTH*stri_pkg::DigitW-1:0]          digits_i,
  input  logic [stri_pkg::HeldSymbols*stri_pkg::SymW-1:0]   alpha_i,
  output logic                                              pop_o,
  output logic [stri_pkg::SymW-1:0]                         symbol_o,
  output logic                                              last_o,
  output logic                                              valid_o
);
  import stri_pkg::*;

  localparam int unsigned IdxW = $clog2(NUMBER_WIDTH);

  typedef enum logic [2:0] {
    BIdle  = 3'b001,
    BSign  = 3'b010,
    BDigit = 3'b100
  } back_state_e;

  back_state_e        state_q, state_d;
  logic [IdxW-1:0]    pos_q;
  logic               valid_q;
  logic [SymW-1:0]    symbol_q;
  logic               last_q;
  logic [DigitW-1:0]  dig [NUMBER_WIDTH];
  logic [DigitW-1:0]  digit_cur;

  for (genvar g = 0; g < NUMBER_WIDTH; g++) begin : g_unflat
    assign dig[g] = digits_i[g*DigitW +: DigitW];
  end

  assign digit_cur = dig[pos_q];

  always_comb begin
    state_d = state_q;
    case (state_q)
      BIdle: begin
        if (!empty_i) state_d = neg_i ? BSign : BDigit;
      end
      BSign: begin
        state_d = BDigit;
      end
      BDigit: begin
        if (pos_q == '0) state_d = BIdle;
      end
      default: state_d = BIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BIdle;
      pos_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= (state_q == BSign) || (state_q == BDigit);
      if (state_q == BIdle && !empty_i) begin
        pos_q <= IdxW'(nd_i - 1'b1);
      end else if (state_q == BDigit && pos_q != '0) begin
        pos_q <= pos_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == BSign) begin
      symbol_q <= ChMinus;
      last_q   <= 1'b0;
    end else if (state_q == BDigit) begin
      symbol_q <= sym_at(alpha_i, digit_cur);
      last_q   <= (pos_q == '0);
    end
  end

  assign pop_o    = (state_q == BDigit) && (pos_q == '0);
  assign symbol_o = symbol_q;
  assign last_o   = last_q;
  assign valid_o  = valid_q;

  a_sign_then_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BSign) |=> (state_q == BDigit))
    else $error("sign not followed by digit");

  a_last_on_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (valid_o && last_o))
    else $error("final beat not flagged after pop");

endmodule

`default_nettype wire

### rtl/signed_integer_to_radix_digits_top.sv
// ----------------------------------------------------------------------------
// signed_integer_to_radix_digits_top
// Signed integer to text in a configurable radix, most significant first.
//
//   channel  dir  handshake            payload
//   number   in   start / busy         number_i
//   symbol   out  valid_o (strobe)     symbol_o, last_o
//   config   in   cfg_we_i             cfg_idx_i, cfg_data_i
//
// The front holds busy through the alphabet check, the divide of each of
// the digits at 8 quotient bits per cycle, and any wait on a full queue;
// a bad alphabet makes it drop the number at the check.
// The back emits the sign if negative, then the digits, one beat per cycle
// within a number, from a two-entry queue, so it overlaps the next divide.
// Reset restores the default decimal alphabet; the receiver cannot stall.
// ----------------------------------------------------------------------------
`default_nettype none

module signed_integer_to_radix_digits_top #(
  parameter int unsigned NUMBER_WIDTH = stri_pkg::NumberWidthDefault
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [NUMBER_WIDTH-1:0]     number_i,
  input  logic                               cfg_we_i,
  input  logic [stri_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [stri_pkg::AlphaW-1:0]        cfg_data_i,
  output logic [stri_pkg::SymW-1:0]          symbol_o,
  output logic                               last_o,
  output logic                               valid_o
);
  import stri_pkg::*;

  localparam int unsigned NdW  = $clog2(NUMBER_WIDTH + 1);
  localparam int unsigned DigW = NUMBER_WIDTH * DigitW;
  localparam int unsigned EntW = 1 + NdW + DigW;

  logic [CountW-1:0]              count_q;
  logic [AlphaW-1:0]              alpha_lo_q;
  logic [AlphaW-1:0]              alpha_hi_q;
  logic [HeldSymbols*SymW-1:0]    alpha;

  logic             push;
  logic             full;
  logic             pop;
  logic             empty;
  logic             f_neg;
  logic [NdW-1:0]   f_nd;
  logic [DigW-1:0]  f_digits;
  logic [EntW-1:0]  q_in;
  logic [EntW-1:0]  q_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= CountRst;
      alpha_lo_q <= AlphaLoRst;
      alpha_hi_q <= AlphaHiRst;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        RegCount:   count_q    <= cfg_data_i[CountW-1:0];
        RegAlphaLo: alpha_lo_q <= cfg_data_i;
        RegAlphaHi: alpha_hi_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign alpha = {alpha_hi_q, alpha_lo_q};

  stri_front #(
    .NUMBER_WIDTH(NUMBER_WIDTH)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .busy_o   (busy),
    .number_i (number_i),
    .count_i  (count_q),
    .alpha_i  (alpha),
    .full_i   (full),
    .push_o   (push),
    .neg_o    (f_neg),
    .nd_o     (f_nd),
    .digits_o (f_digits)
  );

  assign q_in = {f_neg, f_nd, f_digits};

  stri_queue #(
    .WIDTH(EntW)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (q_in),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (q_out),
    .empty_o (empty)
  );

  stri_back #(
    .NUMBER_WIDTH(NUMBER_WIDTH)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .empty_i  (empty),
    .neg_i    (q_out[EntW-1]),
    .nd_i     (q_out[DigW +: NdW]),
    .digits_i (q_out[DigW-1:0]),
    .alpha_i  (alpha),
    .pop_o    (pop),
    .symbol_o (symbol_o),
    .last_o   (last_o),
    .valid_o  (valid_o)
  );

endmodule

`default_nettype wire
